/* hw/rtl/utf8sd_pkg.sv */
package utf8sd_pkg;

  localparam int OffsetBits = 16;
  localparam int StartOffW  = 16;
  localparam int OffExtW    = (OffsetBits > StartOffW) ? OffsetBits : StartOffW;
  localparam int CpW        = 21;

  localparam logic [CpW-1:0] ReplCp = CpW'(32'h0000_FFFD);

  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  typedef struct packed {
    logic [CpW-1:0]       cp;
    logic [StartOffW-1:0] off;
  } res_t;

  // one queue entry holds every result caused by one byte
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
    logic fin;
  } qent_t;

  function automatic logic [StartOffW-1:0] off_field(input logic [OffsetBits-1:0] v);
    logic [OffExtW-1:0] ext;
    ext = OffExtW'(v);
    return ext[StartOffW-1:0];
  endfunction

endpackage

/* hw/rtl/utf8sd_front.sv */
module utf8sd_front import utf8sd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       final_byte_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output qent_t      q_data_o
);

  logic [CpW-1:0]        acc_q, acc_d;
  logic [1:0]            rem_q, rem_d;
  logic [OffsetBits-1:0] seq_q, seq_d;
  logic [OffsetBits-1:0] pos_q;

  logic           accept;
  logic           is_cont, in_seq, cont_ok;
  logic [CpW-1:0] acc_cont;
  logic [1:0]     rem_dec;
  logic           a_v, b_v, c_v;
  logic [CpW-1:0] a_cp, b_cp;
  res_t           res_a, res_b, res_c;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  assign is_cont  = (text_byte_i[7:6] == 2'b10);
  assign in_seq   = (rem_q != 2'd0);
  assign cont_ok  = in_seq && is_cont;
  assign acc_cont = {acc_q[CpW-7:0], text_byte_i[5:0]};
  assign rem_dec  = rem_q - 2'd1;

  always_comb begin
    acc_d = acc_q;
    rem_d = rem_q;
    seq_d = seq_q;
    a_v   = 1'b0;
    a_cp  = ReplCp;
    b_v   = 1'b0;
    b_cp  = ReplCp;
    if (cont_ok) begin
      acc_d = acc_cont;
      rem_d = rem_dec;
      a_v   = (rem_dec == 2'd0);
      a_cp  = acc_cont;
    end else begin
      // bad continuation closes the open sequence, byte is then a new lead
      a_v   = in_seq;
      rem_d = 2'd0;
      priority if (!text_byte_i[7]) begin
        b_v  = 1'b1;
        b_cp = CpW'(text_byte_i);
      end else if (!text_byte_i[6]) begin
        b_v = 1'b1;
      end else if (!text_byte_i[5]) begin
        acc_d = CpW'(text_byte_i[4:0]);
        rem_d = 2'd1;
        seq_d = pos_q;
      end else if (!text_byte_i[4]) begin
        acc_d = CpW'(text_byte_i[3:0]);
        rem_d = 2'd2;
        seq_d = pos_q;
      end else begin
        // 0xF8..0xFF taken as four-byte leads too
        acc_d = CpW'(text_byte_i[2:0]);
        rem_d = 2'd3;
        seq_d = pos_q;
      end
    end
    c_v = final_byte_i && (rem_d != 2'd0);
  end

  assign res_a = '{cp: a_cp,   off: off_field(seq_q)};
  assign res_b = '{cp: b_cp,   off: off_field(pos_q)};
  assign res_c = '{cp: ReplCp, off: off_field(seq_d)};

  always_comb begin
    q_data_o.r0  = a_v ? res_a : (b_v ? res_b : res_c);
    q_data_o.r1  = (a_v && b_v) ? res_b : res_c;
    q_data_o.two = (a_v && b_v) || (a_v && c_v) || (b_v && c_v);
    q_data_o.fin = final_byte_i;
  end

  assign q_push_o = accept && (a_v || b_v || c_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      rem_q <= '0;
      seq_q <= '0;
      pos_q <= '0;
    end else if (accept) begin
      if (final_byte_i) begin
        acc_q <= '0;
        rem_q <= '0;
        seq_q <= '0;
        pos_q <= '0;
      end else begin
        acc_q <= acc_d;
        rem_q <= rem_d;
        seq_q <= seq_d;
        if (pos_q != '1) begin
          pos_q <= pos_q + 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/utf8sd_fifo.sv */
module utf8sd_fifo import utf8sd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  not_empty_o,
  output qent_t head_o
);

  qent_t             mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoAw:0]   cnt_q;

  assign full_o      = (cnt_q == (FifoAw+1)'(FifoDepth));
  assign not_empty_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/utf8sd_back.sv */
module utf8sd_back import utf8sd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_not_empty_i,
  input  qent_t                q_head_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CpW-1:0]       code_point_o,
  output logic [StartOffW-1:0] start_offset_o,
  output logic                 run_end_o,
  output logic                 text_end_o
);

  logic                 out_valid_q;
  logic [CpW-1:0]       cp_q;
  logic [StartOffW-1:0] off_q;
  logic                 run_end_q, text_end_q;
  logic                 phase_q;

  logic load, emit;

  assign load    = !out_valid_q || !out_stall_i;
  assign emit    = load && q_not_empty_i;
  // an entry pops with its last result: its only one, or the second half of a two-result entry
  assign q_pop_o = emit && (phase_q || !q_head_i.two);

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (phase_q) begin
        cp_q       <= q_head_i.r1.cp;
        off_q      <= q_head_i.r1.off;
        run_end_q  <= 1'b1;
        text_end_q <= q_head_i.fin;
      end else begin
        cp_q       <= q_head_i.r0.cp;
        off_q      <= q_head_i.r0.off;
        run_end_q  <= !q_head_i.two;
        text_end_q <= !q_head_i.two && q_head_i.fin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else if (load) begin
      out_valid_q <= q_not_empty_i;
      if (q_not_empty_i) begin
        phase_q <= !phase_q && q_head_i.two;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign code_point_o   = cp_q;
  assign start_offset_o = off_q;
  assign run_end_o      = run_end_q;
  assign text_end_o     = text_end_q;

endmodule

/* hw/rtl/utf8_stream_decoder_top.sv */
// UTF-8 stream decoder: bytes in, code points out.
// Input channel: one text byte per request (text_byte_i, final_byte_i),
// taken when in_valid_i is high and in_stall_o is low. final_byte_i marks
// the last byte of a text; decode state and the offset counter then clear.
// Output channel: one code point per request with its start offset,
// run_end_o on the last result of a byte and text_end_o on the last of a text.
// Malformed or truncated sequences give U+FFFD.
// Path: the queue entry is written as the byte is taken, and the output
// register is loaded from the queue head once that register is free
// (empty, or its result taken by the receiver).
// Throughput: one byte per cycle while the queue is not full; a byte giving
// two results shows them in turn from the single output register.
// A four-entry queue (at most one entry per byte) sits between decode and output,
// so bytes keep flowing while the receiver stalls until the queue fills;
// in_stall_o is high exactly when it is full.
// Reset clears decode state, the queue and the output valid.
module utf8_stream_decoder_top import utf8sd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           text_byte_i,
  input  logic                 final_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CpW-1:0]       code_point_o,
  output logic [StartOffW-1:0] start_offset_o,
  output logic                 run_end_o,
  output logic                 text_end_o
);

  logic  q_full, q_push, q_pop, q_not_empty;
  qent_t q_wdata, q_head;

  utf8sd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .text_byte_i (text_byte_i),
    .final_byte_i(final_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  utf8sd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_wdata),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .not_empty_o(q_not_empty),
    .head_o     (q_head)
  );

  utf8sd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (q_not_empty),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_point_o  (code_point_o),
    .start_offset_o(start_offset_o),
    .run_end_o     (run_end_o),
    .text_end_o    (text_end_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && !q_not_empty))
    else $error("queue read while empty");

  a_text_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && text_end_o) |-> run_end_o)
    else $error("text end on a result that is not last of its byte");

  a_output_fed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && q_not_empty) |=> out_valid_o)
    else $error("pending result not moved to output");

endmodule

/* tb/utf8_stream_decoder_top_tb.sv */
module utf8_stream_decoder_top_tb;
  import utf8sd_pkg::*;

  localparam int CycleLimit = 2_000_000;
  localparam int RandomBytes = 450;
  localparam int ShownFails = 10;

  typedef struct packed {
    logic [7:0] val;
    logic       fin;
  } byte_req_t;

  typedef struct packed {
    logic [CpW-1:0]       cp;
    logic [StartOffW-1:0] off;
    logic                 run_end;
    logic                 text_end;
  } cp_rec_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           text_byte_i = '0;
  logic                 final_byte_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [CpW-1:0]       code_point_o;
  logic [StartOffW-1:0] start_offset_o;
  logic                 run_end_o;
  logic                 text_end_o;

  utf8_stream_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_byte_i   (text_byte_i),
    .final_byte_i  (final_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_point_o  (code_point_o),
    .start_offset_o(start_offset_o),
    .run_end_o     (run_end_o),
    .text_end_o    (text_end_o)
  );

  byte_req_t bytes_to_send[$];
  cp_rec_t   cp_expected[$];
  int        queued_count = 0;
  int        fail_count = 0;
  int        cycle_count = 0;

  // decoder state as seen by the predictor
  logic [CpW-1:0]       acc_bits = '0;
  logic [1:0]           conts_owed = '0;
  logic [StartOffW-1:0] seq_at = '0;
  logic [StartOffW-1:0] pos_at = '0;

  int send_gap = 0, send_steady = 0;
  int hold_left = 0, hold_steady = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void note_fail(input string msg);
    fail_count++;
    if (fail_count <= ShownFails) $display("mismatch: %s", msg);
  endfunction

  // works out every code point one accepted byte gives, in order
  function automatic void decode_byte(input logic [7:0] b, input logic fin);
    cp_rec_t got[$];
    cp_rec_t rec;
    bit      as_lead;
    as_lead = (conts_owed == 0);
    if (conts_owed != 0) begin
      if (b[7:6] == 2'b10) begin
        acc_bits   = {acc_bits[CpW-7:0], b[5:0]};
        conts_owed = conts_owed - 2'd1;
        if (conts_owed == 0) got.push_back('{acc_bits, seq_at, 1'b0, 1'b0});
      end else begin
        // bad continuation closes the open sequence, byte is retried as a lead
        got.push_back('{ReplCp, seq_at, 1'b0, 1'b0});
        conts_owed = 0;
        as_lead    = 1'b1;
      end
    end
    if (as_lead) begin
      if (b < 8'h80) begin
        got.push_back('{CpW'(b), pos_at, 1'b0, 1'b0});
      end else if (b < 8'hC0) begin
        got.push_back('{ReplCp, pos_at, 1'b0, 1'b0});
      end else begin
        if (b < 8'hE0) begin
          acc_bits   = CpW'(b[4:0]);
          conts_owed = 2'd1;
        end else if (b < 8'hF0) begin
          acc_bits   = CpW'(b[3:0]);
          conts_owed = 2'd2;
        end else begin
          acc_bits   = CpW'(b[2:0]);
          conts_owed = 2'd3;
        end
        seq_at = pos_at;
      end
    end
    if (fin && conts_owed != 0) got.push_back('{ReplCp, seq_at, 1'b0, 1'b0});
    if (got.size() > 0) begin
      got[got.size()-1].run_end  = 1'b1;
      got[got.size()-1].text_end = fin;
    end
    foreach (got[i]) cp_expected.push_back(got[i]);
    if (fin) begin
      acc_bits   = '0;
      conts_owed = '0;
      seq_at     = '0;
      pos_at     = '0;
    end else if (pos_at != '1) begin
      pos_at = pos_at + 1'b1;
    end
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    byte_req_t req;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      text_byte_i  <= '0;
      final_byte_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) decode_byte(text_byte_i, final_byte_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0 || bytes_to_send.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid_i   <= 1'b0;
          text_byte_i  <= 8'($urandom);
          final_byte_i <= 1'($urandom);
        end else begin
          req = bytes_to_send.pop_front();
          in_valid_i   <= 1'b1;
          text_byte_i  <= req.val;
          final_byte_i <= req.fin;
          if (send_steady > 0) begin
            send_steady--;
          end else begin
            send_gap = idle_len();
            if ($urandom_range(0, 19) == 0) send_steady = $urandom_range(16, 48);
          end
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    cp_rec_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (cp_expected.size() == 0) begin
          note_fail($sformatf("unexpected cp=%h off=%0d run_end=%b text_end=%b",
                              code_point_o, start_offset_o, run_end_o, text_end_o));
        end else begin
          want = cp_expected.pop_front();
          if (code_point_o !== want.cp || start_offset_o !== want.off ||
              run_end_o !== want.run_end || text_end_o !== want.text_end)
            note_fail($sformatf({"cp exp %h got %h, off exp %0d got %0d, ",
                                 "run_end exp %b got %b, text_end exp %b got %b"},
                                want.cp, code_point_o, want.off, start_offset_o,
                                want.run_end, run_end_o, want.text_end, text_end_o));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (hold_steady > 0) begin
          hold_steady--;
        end else begin
          hold_left = idle_len();
          if ($urandom_range(0, 19) == 0) hold_steady = $urandom_range(16, 48);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("utf8_stream_decoder_top_tb NOT OK");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic fin);
    bytes_to_send.push_back('{b, fin});
    queued_count++;
  endtask

  // well-formed encoding of cp in n bytes
  task automatic add_seq(input logic [CpW-1:0] cp, input int n, input logic fin);
    case (n)
      1: add_byte({1'b0, cp[6:0]}, fin);
      2: begin
        add_byte({3'b110, cp[10:6]}, 1'b0);
        add_byte({2'b10, cp[5:0]}, fin);
      end
      3: begin
        add_byte({4'b1110, cp[15:12]}, 1'b0);
        add_byte({2'b10, cp[11:6]}, 1'b0);
        add_byte({2'b10, cp[5:0]}, fin);
      end
      default: begin
        add_byte({5'b11110, cp[20:18]}, 1'b0);
        add_byte({2'b10, cp[17:12]}, 1'b0);
        add_byte({2'b10, cp[11:6]}, 1'b0);
        add_byte({2'b10, cp[5:0]}, fin);
      end
    endcase
  endtask

  task automatic drain();
    while (bytes_to_send.size() != 0 || in_valid_i || cp_expected.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    int start_count, units, n, r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // 0x00 and the upper range end of each sequence length
    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_seq(21'h0007FF, 2, 1'b0);
    add_seq(21'h00FFFF, 3, 1'b0);
    add_seq(21'h10FFFF, 4, 1'b1);
    // stray continuation, bad continuation, cut short at the end
    add_byte(8'h80, 1'b0);
    add_byte(8'hC3, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'hE2, 1'b0);
    add_byte(8'h82, 1'b1);
    // 0xF8..0xFF lead taken as four-byte
    add_byte(8'hFF, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hBF, 1'b1);
    // bad continuation whose retried lead is itself cut short: two results
    add_byte(8'hE1, 1'b0);
    add_byte(8'hC3, 1'b0);
    add_byte(8'hF0, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h41, 1'b1);
    drain();

    start_count = queued_count;
    while (queued_count - start_count < RandomBytes) begin
      units = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      for (int u = 0; u < units; u++) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          n = $urandom_range(1, 4);
          add_seq(21'($urandom), n, 1'b0);
        end else if (r < 80) begin
          add_byte(8'($urandom), 1'b0);
        end else if (r < 88) begin
          // lead with too few continuations
          n = $urandom_range(2, 4);
          add_byte((n == 2) ? (8'hC0 | 8'($urandom_range(0, 31))) :
                   (n == 3) ? (8'hE0 | 8'($urandom_range(0, 15))) :
                              (8'hF0 | 8'($urandom_range(0, 15))), 1'b0);
          repeat ($urandom_range(0, n - 2)) add_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
        end else if (r < 94) begin
          add_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
        end else begin
          add_byte(8'hF8 | 8'($urandom_range(0, 7)), 1'b0);
          repeat (3) add_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
        end
      end
      bytes_to_send[bytes_to_send.size()-1].fin = 1'b1;
    end
    drain();
    repeat (8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("utf8_stream_decoder_top_tb OK");
    end else begin
      $display("utf8_stream_decoder_top_tb NOT OK");
    end
    $finish;
  end

endmodule
